/* design/rhc_pkg.sv */
// Shared constants, types and codes of the RGB/HSV colour converter.
package rhc_pkg;

  localparam int CH_BITS       = 12;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_BITS      = 9 + HUE_FRAC_BITS;
  localparam int X_BITS        = (HUE_BITS > CH_BITS) ? HUE_BITS : CH_BITS;

  localparam int SECTOR    = 60 << HUE_FRAC_BITS;
  localparam int FULL_TURN = 360 << HUE_FRAC_BITS;
  localparam int REM_BITS  = HUE_FRAC_BITS + 6;
  localparam int ABS_BITS  = CH_BITS + 3;

  // quotient must hold a hue below five sectors and a saturation of 1.0
  localparam int DIV_Q_BITS = (HUE_BITS > CH_BITS + 1) ? HUE_BITS : CH_BITS + 1;
  localparam int DIV_N_BITS = DIV_Q_BITS + CH_BITS;

  // x / SECTOR == (x >> (HUE_FRAC_BITS + 2)) / 15, the latter by reciprocal
  localparam int RCP_SHIFT = CH_BITS + 8;
  localparam int RCP_MUL   = ((1 << RCP_SHIFT) + 14) / 15;
  localparam int RCP_BITS  = CH_BITS + 5;
  localparam int RCP_Y_BITS = CH_BITS + 4;

  localparam int DATA_FIELD_BITS = X_BITS + 2 * CH_BITS;
  localparam int TDATA_BITS      = ((DATA_FIELD_BITS + 7) / 8) * 8;

  typedef logic [CH_BITS-1:0] chan_t;
  typedef logic [X_BITS-1:0]  xval_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  typedef enum logic {
    OP_TO_HSV = 1'b0,
    OP_TO_RGB = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

endpackage

/* design/rhc_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module rhc_div #(
  parameter int DEN_BITS = 12,
  parameter int QUO_BITS = 15
) (
  input  logic                         clk_i,
  input  logic [QUO_BITS-1:0]          en_i,
  input  logic [QUO_BITS+DEN_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0]          den_i,
  output logic [QUO_BITS-1:0]          quo_o
);

  logic [DEN_BITS-1:0] rem_q [QUO_BITS];
  logic [DEN_BITS-1:0] rem_d [QUO_BITS];
  logic [QUO_BITS-1:0] nq_q  [QUO_BITS];
  logic [QUO_BITS-1:0] nq_d  [QUO_BITS];
  logic [DEN_BITS-1:0] den_q [QUO_BITS];
  logic [DEN_BITS-1:0] den_d [QUO_BITS];

  // nq holds the unconsumed numerator bits on top and quotient bits below
  always_comb begin
    logic [DEN_BITS-1:0] rem_in;
    logic [QUO_BITS-1:0] nq_in;
    logic [DEN_BITS:0]   trial;
    logic                ge;
    for (int j = 0; j < QUO_BITS; j++) begin
      if (j == 0) begin
        rem_in   = num_i[QUO_BITS +: DEN_BITS];
        nq_in    = num_i[QUO_BITS-1:0];
        den_d[j] = den_i;
      end else begin
        rem_in   = rem_q[j-1];
        nq_in    = nq_q[j-1];
        den_d[j] = den_q[j-1];
      end
      trial    = {rem_in, nq_in[QUO_BITS-1]};
      ge       = trial >= {1'b0, den_d[j]};
      rem_d[j] = ge ? DEN_BITS'(trial - {1'b0, den_d[j]}) : DEN_BITS'(trial);
      nq_d[j]  = {nq_in[QUO_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QUO_BITS; j++) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d[j];
        nq_q[j]  <= nq_d[j];
        den_q[j] <= den_d[j];
      end
    end
  end

  assign quo_o = nq_q[QUO_BITS-1];

endmodule

/* design/rgb_hsv_converter_top.sv */
// Top level of the RGB/HSV colour converter: stream ports and pipeline.
//
// Converts one colour per transfer, RGB to HSV when tuser is 0 and HSV to RGB
// when tuser is 1. Channels are unsigned Q0.12, hue is degrees in Q9.6, and
// every quotient truncates. The block takes one transfer per clock while its
// output is not stalled. The pipeline depth is set by the two 15-stage
// restoring dividers that form saturation and hue side by
// side. The reverse direction runs in the first five stages and rides along
// with the dividers. A stalled output holds its result while the stages
// behind it keep filling their empty slots, so no bubble blocks input.
module rgb_hsv_converter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // x_in [14:0], y_in [26:15], z_in [38:27], zero pad [39]
  input  logic [rhc_pkg::TDATA_BITS-1:0] s_axis_tdata,
  // opcode
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // x_out [14:0], y_out [26:15], z_out [38:27], zero pad [39]
  output logic [rhc_pkg::TDATA_BITS-1:0] m_axis_tdata,
  // hue_valid
  output logic                           m_axis_tuser
);

  localparam int CB   = rhc_pkg::CH_BITS;
  localparam int XB   = rhc_pkg::X_BITS;
  localparam int QW   = rhc_pkg::DIV_Q_BITS;
  localparam int NW   = rhc_pkg::DIV_N_BITS;
  localparam int NS   = QW + 3;
  localparam int RB   = rhc_pkg::REM_BITS;
  localparam int AB   = rhc_pkg::ABS_BITS;
  localparam int PB   = CB + RB;
  localparam int YB   = rhc_pkg::RCP_Y_BITS;
  localparam int MB   = rhc_pkg::RCP_BITS;
  localparam int SHR  = rhc_pkg::HUE_FRAC_BITS + 2;
  localparam int RGB_STAGE = 4;

  typedef struct packed {
    rhc_pkg::op_e   op;
    logic           neg;
    rhc_pkg::chan_t mx;
    rhc_pkg::rgb_t  rgb;
  } side_t;

  // ---------------------------------------------------------------- control
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // a stage may load when it is empty or the stage after it moves on
  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  // input fields
  rhc_pkg::xval_t x_in;
  rhc_pkg::chan_t y_in, z_in, r_in;

  assign x_in = s_axis_tdata[XB-1:0];
  assign r_in = s_axis_tdata[CB-1:0];
  assign y_in = s_axis_tdata[XB +: CB];
  assign z_in = s_axis_tdata[XB+CB +: CB];

  rhc_pkg::chan_t mx0, mn0, d0;
  logic [AB-1:0]  abs0;
  logic           neg0;
  logic [3:0]     cnt0;
  rhc_pkg::xval_t base0;
  logic [2:0]     sec0;

  // forward: extremes, spread and the sector numerator as magnitude and sign
  always_comb begin
    mx0 = r_in;
    mn0 = r_in;
    if (y_in > mx0) mx0 = y_in;
    if (z_in > mx0) mx0 = z_in;
    if (y_in < mn0) mn0 = y_in;
    if (z_in < mn0) mn0 = z_in;
    d0   = mx0 - mn0;
    neg0 = 1'b0;
    if (r_in == mx0) begin
      neg0 = y_in < z_in;
      abs0 = neg0 ? AB'(z_in - y_in) : AB'(y_in - z_in);
    end else if (y_in == mx0) begin
      abs0 = (AB'(d0) << 1) + AB'(z_in) - AB'(r_in);
    end else begin
      abs0 = (AB'(d0) << 2) + AB'(r_in) - AB'(y_in);
    end
  end

  // reverse: sector by compare against multiples of one sector, then wrap
  always_comb begin
    cnt0  = '0;
    base0 = '0;
    for (int k = 1; k <= 8; k++) begin
      if (x_in >= XB'(k * rhc_pkg::SECTOR)) begin
        cnt0  = 4'(k);
        base0 = XB'(k * rhc_pkg::SECTOR);
      end
    end
    sec0 = (cnt0 >= 4'd6) ? 3'(cnt0 - 4'd6) : cnt0[2:0];
  end

  rhc_pkg::op_e   op0_q;
  logic           neg0_q;
  rhc_pkg::chan_t mx0_q, d0_q;
  logic [AB-1:0]  abs0_q;
  logic [RB-1:0]  rem0_q;
  logic [2:0]     sec0_q;
  rhc_pkg::chan_t s0_q, v0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op0_q  <= rhc_pkg::op_e'(s_axis_tuser);
      neg0_q <= neg0;
      mx0_q  <= mx0;
      d0_q   <= d0;
      abs0_q <= abs0;
      rem0_q <= RB'(x_in - base0);
      sec0_q <= sec0;
      s0_q   <= y_in;
      v0_q   <= z_in;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // divider operands; reverse path forms s*rem and s*(sector - rem)
  logic [NW-1:0]  hnum1_q, snum1_q;
  rhc_pkg::chan_t hden1_q, sden1_q;
  logic [PB-1:0]  sr1_q, st1_q;
  logic [2:0]     sec1_q;
  rhc_pkg::chan_t s1_q, v1_q;
  side_t          sb_q [1:NS-2];
  side_t          sb_d [1:NS-2];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      hnum1_q <= NW'(abs0_q) * NW'(rhc_pkg::SECTOR);
      snum1_q <= NW'(d0_q) << CB;
      hden1_q <= d0_q;
      sden1_q <= mx0_q;
      sr1_q   <= PB'(s0_q) * PB'(rem0_q);
      st1_q   <= PB'(s0_q) * PB'(RB'(rhc_pkg::SECTOR) - rem0_q);
      sec1_q  <= sec0_q;
      s1_q    <= s0_q;
      v1_q    <= v0_q;
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [QW-1:0] hq, sq;

  rhc_div #(
    .DEN_BITS(CB),
    .QUO_BITS(QW)
  ) u_hue_div (
    .clk_i(clk_i),
    .en_i (en[QW+1:2]),
    .num_i(hnum1_q),
    .den_i(hden1_q),
    .quo_o(hq)
  );

  rhc_div #(
    .DEN_BITS(CB),
    .QUO_BITS(QW)
  ) u_sat_div (
    .clk_i(clk_i),
    .en_i (en[QW+1:2]),
    .num_i(snum1_q),
    .den_i(sden1_q),
    .quo_o(sq)
  );

  // ---------------------------------------------------------------- stage 2
  // fractions s*rem/sector and s*(sector-rem)/sector by reciprocal
  logic [YB+MB-1:0] fqp, ftp;
  rhc_pkg::chan_t   fq2_q, ft2_q, s2_q, v2_q;
  logic [2:0]       sec2_q;

  assign fqp = (YB+MB)'(YB'(sr1_q >> SHR)) * (YB+MB)'(rhc_pkg::RCP_MUL);
  assign ftp = (YB+MB)'(YB'(st1_q >> SHR)) * (YB+MB)'(rhc_pkg::RCP_MUL);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      fq2_q  <= fqp[rhc_pkg::RCP_SHIFT +: CB];
      ft2_q  <= ftp[rhc_pkg::RCP_SHIFT +: CB];
      s2_q   <= s1_q;
      v2_q   <= v1_q;
      sec2_q <= sec1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // p, q and t; zero saturation gives v on all three, hence grey
  logic [2*CB:0]  pp, qp, tp;
  rhc_pkg::chan_t p3_q, q3_q, t3_q, v3_q;
  logic [2:0]     sec3_q;

  assign pp = (2*CB+1)'(v2_q) * (2*CB+1)'((CB+1)'(1 << CB) - (CB+1)'(s2_q));
  assign qp = (2*CB+1)'(v2_q) * (2*CB+1)'((CB+1)'(1 << CB) - (CB+1)'(fq2_q));
  assign tp = (2*CB+1)'(v2_q) * (2*CB+1)'((CB+1)'(1 << CB) - (CB+1)'(ft2_q));

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      p3_q   <= pp[CB +: CB];
      q3_q   <= qp[CB +: CB];
      t3_q   <= tp[CB +: CB];
      v3_q   <= v2_q;
      sec3_q <= sec2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  rhc_pkg::rgb_t rgb4;

  always_comb begin
    unique case (rhc_pkg::sector_e'(sec3_q))
      rhc_pkg::SEC_RED_YELLOW:   rgb4 = '{r: v3_q, g: t3_q, b: p3_q};
      rhc_pkg::SEC_YELLOW_GREEN: rgb4 = '{r: q3_q, g: v3_q, b: p3_q};
      rhc_pkg::SEC_GREEN_CYAN:   rgb4 = '{r: p3_q, g: v3_q, b: t3_q};
      rhc_pkg::SEC_CYAN_BLUE:    rgb4 = '{r: p3_q, g: q3_q, b: v3_q};
      rhc_pkg::SEC_BLUE_MAGENTA: rgb4 = '{r: t3_q, g: p3_q, b: v3_q};
      default:                   rgb4 = '{r: v3_q, g: p3_q, b: q3_q};
    endcase
  end

  // side band walks beside the dividers; reverse result joins at stage 4
  always_comb begin
    sb_d[1] = '{op: op0_q, neg: neg0_q, mx: mx0_q, rgb: '0};
    for (int k = 2; k <= NS - 2; k++) begin
      sb_d[k] = sb_q[k-1];
      if (k == RGB_STAGE) begin
        sb_d[k].rgb = rgb4;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= NS - 2; k++) begin
      if (en[k]) begin
        sb_q[k] <= sb_d[k];
      end
    end
  end

  // ---------------------------------------------------------------- output
  side_t          sbo;
  rhc_pkg::chan_t sat;
  rhc_pkg::xval_t hue;
  logic           hv;
  rhc_pkg::xval_t xo_d;
  rhc_pkg::chan_t yo_d, zo_d;

  assign sbo = sb_q[NS-2];

  // clamp saturation of 1.0, mirror a negative red-sector hue into range
  always_comb begin
    if (sbo.mx == '0) begin
      sat = '0;
    end else if (sq[QW-1:CB] != '0) begin
      sat = '1;
    end else begin
      sat = sq[CB-1:0];
    end
    hv = sat != '0;
    if (sbo.neg && hq != '0) begin
      hue = XB'(rhc_pkg::FULL_TURN) - hq[XB-1:0];
    end else begin
      hue = hq[XB-1:0];
    end
    if (sbo.op == rhc_pkg::OP_TO_HSV) begin
      xo_d = hv ? hue : '0;
      yo_d = sat;
      zo_d = sbo.mx;
    end else begin
      hv   = 1'b0;
      xo_d = XB'(sbo.rgb.r);
      yo_d = sbo.rgb.g;
      zo_d = sbo.rgb.b;
    end
  end

  rhc_pkg::xval_t xo_q;
  rhc_pkg::chan_t yo_q, zo_q;
  logic           hv_q;
  rhc_pkg::op_e   opo_q;

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      xo_q  <= xo_d;
      yo_q  <= yo_d;
      zo_q  <= zo_d;
      hv_q  <= hv;
      opo_q <= sbo.op;
    end
  end

  assign m_axis_tdata = rhc_pkg::TDATA_BITS'({zo_q, yo_q, xo_q});
  assign m_axis_tuser = hv_q;

  // ---------------------------------------------------------------- checks
  a_rev_no_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && opo_q == rhc_pkg::OP_TO_RGB |-> !m_axis_tuser)
    else $error("hue flag set on an HSV to RGB result");

  a_hue_needs_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> yo_q != '0)
    else $error("defined hue with zero saturation");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && opo_q == rhc_pkg::OP_TO_HSV |-> xo_q < XB'(rhc_pkg::FULL_TURN))
    else $error("hue beyond a full turn");

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS-1] |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

endmodule
